>>> sv/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types and constants for the solid brick texture unit.
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam int COORD_W       = 32;
    localparam int SCALE_W       = 32;
    localparam int FRAC_W        = 16;
    localparam int MORTAR_W      = 16;
    localparam int COLOR_PAIR_W  = 48;
    localparam int CHAN_OUT_W    = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int DIV_STEPS     = SCALE_W + FRAC_W;
    localparam int PIPE_DEPTH    = DIV_STEPS + 2;

    localparam int DEF_COORD_FRAC_BITS = 16;
    localparam int DEF_CHANNEL_BITS    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MORTAR     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_PAIR = 3'd7;

    localparam logic [SCALE_W-1:0]      RST_SCALE_XY   = 32'd3276800;
    localparam logic [SCALE_W-1:0]      RST_SCALE_Z    = 32'd16384000;
    localparam logic [MORTAR_W-1:0]     RST_MORTAR     = 16'd6554;
    localparam logic [COLOR_PAIR_W-1:0] RST_COLOR_PAIR = 48'd10047260;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_point_req;

    typedef struct packed {
        logic [CHAN_OUT_W-1:0] red;
        logic [CHAN_OUT_W-1:0] green;
        logic [CHAN_OUT_W-1:0] blue;
        logic                  in_brick;
    } t_texel;

    typedef struct packed {
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
        logic [FRAC_W-1:0] fz;
    } t_frac3;

endpackage

>>> sv/bst_axis_prep.sv
// ----------------------------------------------------------------------------
// bst_axis_prep
// Center subtract and offset add with saturation, then magnitude; registered.
// ----------------------------------------------------------------------------
module bst_axis_prep #(
    parameter int COORD_FRAC_BITS = bst_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [bst_pkg::COORD_W-1:0]  i_point,
    input  logic signed [bst_pkg::COORD_W-1:0]  i_center,
    output logic        [bst_pkg::COORD_W-1:0]  o_mag
);

    localparam longint OFFSET_VAL = ((64'd1 << COORD_FRAC_BITS) + 64'd500) / 64'd1000;
    localparam logic signed [bst_pkg::COORD_W:0] OFFSET = (bst_pkg::COORD_W+1)'(OFFSET_VAL);
    localparam logic signed [bst_pkg::COORD_W:0] SAT_MAX = {2'b00, {(bst_pkg::COORD_W-1){1'b1}}};
    localparam logic signed [bst_pkg::COORD_W:0] SAT_MIN = {2'b11, {(bst_pkg::COORD_W-1){1'b0}}};

    logic signed [bst_pkg::COORD_W:0] diff_wide;
    logic signed [bst_pkg::COORD_W:0] diff_sat;
    logic signed [bst_pkg::COORD_W:0] offs_wide;
    logic signed [bst_pkg::COORD_W:0] offs_sat;
    logic        [bst_pkg::COORD_W:0] neg_val;
    logic        [bst_pkg::COORD_W-1:0] n_mag;
    logic        [bst_pkg::COORD_W-1:0] r_mag;

    always_comb begin
        diff_wide = {i_point[bst_pkg::COORD_W-1], i_point}
                  - {i_center[bst_pkg::COORD_W-1], i_center};
        if (diff_wide > SAT_MAX) begin
            diff_sat = SAT_MAX;
        end else if (diff_wide < SAT_MIN) begin
            diff_sat = SAT_MIN;
        end else begin
            diff_sat = diff_wide;
        end
        offs_wide = diff_sat + OFFSET;
        if (offs_wide > SAT_MAX) begin
            offs_sat = SAT_MAX;
        end else begin
            offs_sat = offs_wide;
        end
        neg_val = -offs_sat;
        n_mag = offs_sat[bst_pkg::COORD_W] ? neg_val[bst_pkg::COORD_W-1:0]
                                           : offs_sat[bst_pkg::COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= n_mag;
        end
    end

    assign o_mag = r_mag;

endmodule

>>> sv/bst_frac_div.sv
// ----------------------------------------------------------------------------
// bst_frac_div
// Pipelined restoring divider, one quotient bit per stage. Divides mag*2^16
// by scale and keeps the low 16 quotient bits: the fraction of mag/scale.
// ----------------------------------------------------------------------------
module bst_frac_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [bst_pkg::COORD_W-1:0]       i_mag,
    input  logic [bst_pkg::SCALE_W-1:0]       i_scale,
    output logic [bst_pkg::FRAC_W-1:0]        o_frac
);

    localparam int STEPS = bst_pkg::DIV_STEPS;

    logic [bst_pkg::SCALE_W-1:0] w_rem [0:STEPS];
    logic [bst_pkg::COORD_W-1:0] w_dvd [0:STEPS];
    logic [bst_pkg::FRAC_W-1:0]  w_quo [0:STEPS];

    assign w_rem[0] = '0;
    assign w_dvd[0] = i_mag;
    assign w_quo[0] = '0;

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        logic [bst_pkg::SCALE_W:0]   cand;
        logic [bst_pkg::SCALE_W:0]   diff;
        logic                        ge;
        logic [bst_pkg::SCALE_W-1:0] r_rem;
        logic [bst_pkg::COORD_W-1:0] r_dvd;
        logic [bst_pkg::FRAC_W-1:0]  r_quo;

        always_comb begin
            cand = {w_rem[k-1], w_dvd[k-1][bst_pkg::COORD_W-1]};
            diff = cand - {1'b0, i_scale};
            ge   = (cand >= {1'b0, i_scale});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= ge ? diff[bst_pkg::SCALE_W-1:0] : cand[bst_pkg::SCALE_W-1:0];
                r_dvd <= {w_dvd[k-1][bst_pkg::COORD_W-2:0], 1'b0};
                r_quo <= {w_quo[k-1][bst_pkg::FRAC_W-2:0], ge};
            end
        end

        assign w_rem[k] = r_rem;
        assign w_dvd[k] = r_dvd;
        assign w_quo[k] = r_quo;
    end

    assign o_frac = w_quo[STEPS];

endmodule

>>> sv/bst_shade.sv
// ----------------------------------------------------------------------------
// bst_shade
// Brick or mortar decision from the three fractions, color pick; registered.
// ----------------------------------------------------------------------------
module bst_shade #(
    parameter int CHANNEL_BITS = bst_pkg::DEF_CHANNEL_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  bst_pkg::t_frac3                      i_frac,
    input  logic [2:0]                           i_scale_zero,
    input  logic [bst_pkg::MORTAR_W-1:0]         i_mortar,
    input  logic [bst_pkg::COLOR_PAIR_W-1:0]     i_color_pair,
    output bst_pkg::t_texel                      o_texel
);

    localparam int SW = bst_pkg::FRAC_W + 3;
    localparam logic signed [SW-1:0] ONE  = SW'(1) <<< bst_pkg::FRAC_W;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (bst_pkg::FRAC_W - 1);
    localparam logic [bst_pkg::COLOR_PAIR_W-1:0] CH_MASK =
        (bst_pkg::COLOR_PAIR_W'(1) << CHANNEL_BITS) - bst_pkg::COLOR_PAIR_W'(1);

    logic signed [SW-1:0] fx, fy, fz, m, fx2, fz2;
    logic lower_ok, upper_ok, brick;
    logic [bst_pkg::COLOR_PAIR_W-1:0] color;
    bst_pkg::t_texel n_texel;
    bst_pkg::t_texel r_texel;

    always_comb begin
        fx  = i_scale_zero[0] ? '0 : SW'(i_frac.fx);
        fy  = i_scale_zero[1] ? '0 : SW'(i_frac.fy);
        fz  = i_scale_zero[2] ? '0 : SW'(i_frac.fz);
        m   = SW'(i_mortar);
        fx2 = fx <<< 1;
        fz2 = fz <<< 1;

        lower_ok = (fx2 > m) && (fx2 < 2 * ONE - m) &&
                   (((fz > m) && (fz < HALF)) || ((fz > HALF + m) && (fz < ONE)));
        upper_ok = (fz2 > m) && (fz2 < 2 * ONE - m) &&
                   (((fx > 0) && (fx2 < ONE - m)) || ((fx2 > ONE + m) && (fx < ONE)));

        if (fy < HALF - m) begin
            brick = lower_ok;
        end else if ((fy > HALF) && (fy < ONE - m)) begin
            brick = upper_ok;
        end else begin
            brick = 1'b0;
        end

        color = brick ? i_color_pair : (i_color_pair >> (3 * CHANNEL_BITS));
        n_texel.red      = bst_pkg::CHAN_OUT_W'((color >> (2 * CHANNEL_BITS)) & CH_MASK);
        n_texel.green    = bst_pkg::CHAN_OUT_W'((color >> CHANNEL_BITS) & CH_MASK);
        n_texel.blue     = bst_pkg::CHAN_OUT_W'(color & CH_MASK);
        n_texel.in_brick = brick;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_texel <= n_texel;
        end
    end

    assign o_texel = r_texel;

endmodule

>>> sv/brick_solid_texture_unit.sv
// ----------------------------------------------------------------------------
// brick_solid_texture_unit
// Solid 3D brick texture: one Q16.16 point in, one brick or mortar color out.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel i_valid/o_stall/i_req carries a point; it is taken at an
//   edge with i_valid high and o_stall low. Response channel o_valid/i_stall/
//   o_rsp carries the color and the in_brick flag.
//   Configuration writes use i_cfg_valid/o_cfg_ready with a register index
//   and data; write them only while no request is in flight.
//   A request passes one prepare stage, 48 divider stages (one quotient
//   bit each, set by the 32+16 bit restoring division per axis), one
//   shading stage and the output register.
//   Throughput is one request per cycle while o_stall is low.
//   Reset clears all valid bits and loads the register defaults.
//   When the receiver stalls, the pipeline keeps going until one response
//   sits in the skid register; then o_stall rises and every stage holds.
// ----------------------------------------------------------------------------
module brick_solid_texture_unit #(
    parameter int COORD_FRAC_BITS = bst_pkg::DEF_COORD_FRAC_BITS,
    parameter int CHANNEL_BITS    = bst_pkg::DEF_CHANNEL_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  bst_pkg::t_point_req                  i_req,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output bst_pkg::t_texel                      o_rsp,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bst_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bst_pkg::COLOR_PAIR_W-1:0]     i_cfg_data
);

    localparam int DEPTH = bst_pkg::PIPE_DEPTH;

    logic signed [bst_pkg::COORD_W-1:0] r_center_x, r_center_y, r_center_z;
    logic [bst_pkg::SCALE_W-1:0]        r_scale_x, r_scale_y, r_scale_z;
    logic [bst_pkg::MORTAR_W-1:0]       r_mortar;
    logic [bst_pkg::COLOR_PAIR_W-1:0]   r_color_pair;

    logic [DEPTH-1:0] r_vpipe;
    logic             r_out_valid, r_skid_valid;
    bst_pkg::t_texel  r_out, r_skid;
    logic             en;

    logic [bst_pkg::COORD_W-1:0] mag_x, mag_y, mag_z;
    bst_pkg::t_frac3             frac;
    bst_pkg::t_texel             shade_texel;

    assign o_cfg_ready = 1'b1;
    assign en          = !r_skid_valid;
    assign o_stall     = r_skid_valid;
    assign o_valid     = r_out_valid;
    assign o_rsp       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_center_z   <= '0;
            r_scale_x    <= bst_pkg::RST_SCALE_XY;
            r_scale_y    <= bst_pkg::RST_SCALE_XY;
            r_scale_z    <= bst_pkg::RST_SCALE_Z;
            r_mortar     <= bst_pkg::RST_MORTAR;
            r_color_pair <= bst_pkg::RST_COLOR_PAIR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bst_pkg::REG_CENTER_X:   r_center_x   <= i_cfg_data[bst_pkg::COORD_W-1:0];
                bst_pkg::REG_CENTER_Y:   r_center_y   <= i_cfg_data[bst_pkg::COORD_W-1:0];
                bst_pkg::REG_CENTER_Z:   r_center_z   <= i_cfg_data[bst_pkg::COORD_W-1:0];
                bst_pkg::REG_SCALE_X:    r_scale_x    <= i_cfg_data[bst_pkg::SCALE_W-1:0];
                bst_pkg::REG_SCALE_Y:    r_scale_y    <= i_cfg_data[bst_pkg::SCALE_W-1:0];
                bst_pkg::REG_SCALE_Z:    r_scale_z    <= i_cfg_data[bst_pkg::SCALE_W-1:0];
                bst_pkg::REG_MORTAR:     r_mortar     <= i_cfg_data[bst_pkg::MORTAR_W-1:0];
                bst_pkg::REG_COLOR_PAIR: r_color_pair <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bst_axis_prep #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_prep_x (
        .i_clk(i_clk), .i_en(en), .i_point(i_req.point_x), .i_center(r_center_x), .o_mag(mag_x)
    );
    bst_axis_prep #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_prep_y (
        .i_clk(i_clk), .i_en(en), .i_point(i_req.point_y), .i_center(r_center_y), .o_mag(mag_y)
    );
    bst_axis_prep #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_prep_z (
        .i_clk(i_clk), .i_en(en), .i_point(i_req.point_z), .i_center(r_center_z), .o_mag(mag_z)
    );

    bst_frac_div u_div_x (
        .i_clk(i_clk), .i_en(en), .i_mag(mag_x), .i_scale(r_scale_x), .o_frac(frac.fx)
    );
    bst_frac_div u_div_y (
        .i_clk(i_clk), .i_en(en), .i_mag(mag_y), .i_scale(r_scale_y), .o_frac(frac.fy)
    );
    bst_frac_div u_div_z (
        .i_clk(i_clk), .i_en(en), .i_mag(mag_z), .i_scale(r_scale_z), .o_frac(frac.fz)
    );

    bst_shade #(.CHANNEL_BITS(CHANNEL_BITS)) u_shade (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_frac       (frac),
        .i_scale_zero ({r_scale_z == '0, r_scale_y == '0, r_scale_x == '0}),
        .i_mortar     (r_mortar),
        .i_color_pair (r_color_pair),
        .o_texel      (shade_texel)
    );

    // advance valid bits with the data; output register backed by one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpipe      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (en) begin
                r_vpipe <= {r_vpipe[DEPTH-2:0], i_valid};
            end
            if (!r_out_valid || !i_stall) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= r_vpipe[DEPTH-1];
                    r_out       <= shade_texel;
                end
            end else if (en && r_vpipe[DEPTH-1]) begin
                r_skid       <= shade_texel;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule
